// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/wfptr_pkg.sv =====
`default_nettype none
package wfptr_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int DATA_W      = 16;
	localparam int BASIS_W     = 16;
	localparam int IDX_W       = 10;
	localparam int CNT_W       = 11;
	localparam int SUM_W       = 27;
	localparam int PRD_W       = DATA_W + BASIS_W;
	localparam int PSUM_W      = 42;
	localparam int MP_W        = DATA_W + SUM_W;
	localparam int TILT_W      = 44;
	localparam int COEF_W      = 32;
	localparam int COEF_SH     = 7;
	localparam int RD_SH       = 23;
	localparam int RDP_W       = BASIS_W + COEF_W;
	localparam int V_W         = 50;
	localparam int DIV_W       = 27;
	localparam int DIV_CNT_W   = 5;
	localparam int RAM_W       = DATA_W + 2 * BASIS_W;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PISTON_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_ENABLE   = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic ST_VALID     = 1'b0;
	localparam logic ST_NOT_READY = 1'b1;

	typedef struct packed {
		logic capture;
		logic ld_mul;
		logic ld_acc;
		logic div_init;
		logic div_step;
		logic mean_set;
		logic coef_mul;
		logic coef_fin;
		logic rd_addr;
		logic rd_mul_x;
		logic rd_mul_y;
		logic rd_fin;
	} cmd_t;

	typedef struct packed {
		logic ld_last;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/wavefront_piston_tilt_removal_core.sv =====
// Channel  Direction  Word
// s_*      in         tdata: sample_value[15:0] basis_x[31:16] basis_y[47:32]
//                     read_index[57:48]; tuser: operation
// m_*      out        tdata: corrected_value[15:0] result_index[25:16];
//                     tuser: status; tlast: last_flag
// cfg_*    in         cfg_index register number, cfg_data value
//
// A load is captured, multiplied and accumulated; a frame's last load then runs the
// 27-step restoring divider that forms the mean and the two tilt coefficient steps.
// A read passes the registered RAM read and the two tilt multiplies before its result is written.
// arst_n clears the frame counter, sums, coefficients and config registers to defaults.
// A stalled result word is held in the output register; the next input word is
// still taken and processed up to the point where its result is written.
`default_nettype none
module wavefront_piston_tilt_removal_core
	import wfptr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [63:0]           s_tdata,  // sample_value, basis_x, basis_y, read_index
	input  wire logic                  s_tuser,  // operation
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [31:0]                m_tdata,  // corrected_value, result_index
	output logic                       m_tuser,  // status
	output logic                       m_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t             cmd;
	sts_t             sts;
	logic [DATA_W-1:0] out_value;
	logic [IDX_W-1:0]  out_index;

	assign cfg_ready = 1'b1;

	wfptr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wfptr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_data    (s_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (out_value),
		.out_index  (out_index),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

	assign m_tdata = {6'b0, out_index, out_value};

endmodule
`default_nettype wire

// ===== rtl/wfptr_ram.sv =====
`default_nettype none
module wfptr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wfptr_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module wfptr_ctrl
	import wfptr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	input  wire logic s_tuser,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_LD_MUL   = 4'd1;
	localparam logic [3:0] S_LD_ACC   = 4'd2;
	localparam logic [3:0] S_DIV_INIT = 4'd3;
	localparam logic [3:0] S_DIV      = 4'd4;
	localparam logic [3:0] S_MEAN     = 4'd5;
	localparam logic [3:0] S_COEF_MUL = 4'd6;
	localparam logic [3:0] S_COEF_FIN = 4'd7;
	localparam logic [3:0] S_RD_ADDR  = 4'd8;
	localparam logic [3:0] S_RD_MUL_X = 4'd9;
	localparam logic [3:0] S_RD_MUL_Y = 4'd10;
	localparam logic [3:0] S_RD_FIN   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = (s_tuser == OP_READ) ? S_RD_ADDR : S_LD_MUL;
				end
			end
			S_LD_MUL: begin
				cmd.ld_mul = 1'b1;
				state_d = S_LD_ACC;
			end
			S_LD_ACC: begin
				cmd.ld_acc = 1'b1;
				state_d = sts.ld_last ? S_DIV_INIT : S_IDLE;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_MEAN;
				end
			end
			S_MEAN: begin
				cmd.mean_set = 1'b1;
				state_d = S_COEF_MUL;
			end
			S_COEF_MUL: begin
				cmd.coef_mul = 1'b1;
				state_d = S_COEF_FIN;
			end
			S_COEF_FIN: begin
				cmd.coef_fin = 1'b1;
				state_d = S_IDLE;
			end
			S_RD_ADDR: begin
				cmd.rd_addr = 1'b1;
				state_d = S_RD_MUL_X;
			end
			S_RD_MUL_X: begin
				cmd.rd_mul_x = 1'b1;
				state_d = S_RD_MUL_Y;
			end
			S_RD_MUL_Y: begin
				cmd.rd_mul_y = 1'b1;
				state_d = S_RD_FIN;
			end
			S_RD_FIN: begin
				// The result register must be free before the word is written.
				if (!sts.out_busy) begin
					cmd.rd_fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_ALWAYS(a_one_step, clk, arst_n, $onehot0({cmd.ld_mul, cmd.ld_acc, cmd.div_init, cmd.div_step, cmd.mean_set, cmd.coef_mul, cmd.coef_fin, cmd.rd_addr, cmd.rd_mul_x, cmd.rd_mul_y, cmd.rd_fin}), "more than one datapath step at once")
	`ASSERT_IMPL(a_fin_free, clk, arst_n, cmd.rd_fin, !sts.out_busy, "result written while output stalled")

endmodule
`default_nettype wire

// ===== rtl/wfptr_dp.sv =====
`default_nettype none
`include "assert_macros.svh"
module wfptr_dp
	import wfptr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic [63:0]           in_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_W-1:0]          out_value,
	output logic [IDX_W-1:0]           out_index,
	output logic                       out_status,
	output logic                       out_last
);

	localparam int RC_W = TILT_W - COEF_SH;
	localparam int RR_W = V_W - RD_SH;
	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [COEF_W-1:0] CSAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] CSAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	// Configuration and frame state.
	logic [CNT_W-1:0]         sc_q;
	logic                     pe_q;
	logic                     te_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ready_q;
	logic signed [SUM_W-1:0]  sum_s_q;
	logic signed [SUM_W-1:0]  sum_bx_q;
	logic signed [SUM_W-1:0]  sum_by_q;
	logic signed [PSUM_W-1:0] sum_bxs_q;
	logic signed [PSUM_W-1:0] sum_bys_q;
	logic signed [DATA_W-1:0] mean_q;
	logic signed [COEF_W-1:0] coef_x_q;
	logic signed [COEF_W-1:0] coef_y_q;
	logic [DIV_W-1:0]         quo_q;
	logic [CNT_W-1:0]         rem_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;
	logic                     div_neg_q;
	logic                     out_valid_q;

	// Payload registers.
	logic signed [DATA_W-1:0]  smp_q;
	logic signed [BASIS_W-1:0] bx_q;
	logic signed [BASIS_W-1:0] by_q;
	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W-1:0]          wr_idx_s1;
	logic signed [PRD_W-1:0]   pbx_s1;
	logic signed [PRD_W-1:0]   pby_s1;
	logic signed [MP_W-1:0]    mpx_s1;
	logic signed [MP_W-1:0]    mpy_s1;
	logic signed [RDP_W-1:0]   rpx_s1;
	logic signed [RDP_W-1:0]   rpy_s1;
	logic [DATA_W-1:0]         val_q;
	logic [IDX_W-1:0]          oidx_q;
	logic                      ost_q;
	logic                      olast_q;

	logic [CNT_W-1:0]          n_eff;
	logic                      restart_now;
	logic [IDX_W-1:0]          wr_idx;
	logic [RAM_W-1:0]          ram_rd;
	logic signed [DATA_W-1:0]  rd_s;
	logic signed [BASIS_W-1:0] rd_bx;
	logic signed [BASIS_W-1:0] rd_by;
	logic [CNT_W:0]            trial;
	logic                      qbit;
	logic [SUM_W-1:0]          sum_mag;
	logic [DATA_W:0]           q_mean;
	logic signed [DATA_W-1:0]  m_sel;
	logic [COEF_W-1:0]         coef_x_d;
	logic [COEF_W-1:0]         coef_y_d;
	logic                      rd_ok;
	logic [DATA_W-1:0]         rd_val;

	assign n_eff = (sc_q == '0) ? CNT_W'(1) :
		((sc_q > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : sc_q);
	assign restart_now = ready_q || (cnt_q >= n_eff);
	assign wr_idx      = restart_now ? '0 : cnt_q[IDX_W-1:0];

	wfptr_ram #(.WIDTH(RAM_W), .DEPTH(MAX_SAMPLES)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.ld_mul),
		.wr_addr (wr_idx),
		.wr_data ({by_q, bx_q, smp_q}),
		.rd_en   (cmd.rd_addr),
		.rd_addr (idx_q),
		.rd_data (ram_rd)
	);

	assign rd_s  = ram_rd[DATA_W-1:0];
	assign rd_bx = ram_rd[DATA_W+BASIS_W-1:DATA_W];
	assign rd_by = ram_rd[RAM_W-1:DATA_W+BASIS_W];

	// Restoring divider step, one quotient bit a cycle.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign qbit  = (trial >= {1'b0, n_eff});
	assign sum_mag = sum_s_q[SUM_W-1] ? SUM_W'(-sum_s_q) : SUM_W'(sum_s_q);
	assign q_mean  = quo_q[DATA_W:0];
	assign m_sel   = pe_q ? mean_q : '0;

	function automatic logic [COEF_W-1:0] coef_round(input logic signed [PSUM_W-1:0] ps,
		input logic signed [MP_W-1:0] mp);
		logic signed [TILT_W-1:0] t;
		logic [TILT_W-1:0]        mag;
		logic [TILT_W-1:0]        rs;
		logic [RC_W-1:0]          r;
		logic [COEF_W-1:0]        res;
		t   = TILT_W'(ps) - TILT_W'(mp);
		mag = t[TILT_W-1] ? TILT_W'(-t) : TILT_W'(t);
		rs  = mag + TILT_W'(1 << (COEF_SH - 1));
		r   = rs[TILT_W-1:COEF_SH];
		if (t[TILT_W-1]) begin
			if ((|r[RC_W-1:COEF_W]) || (r[COEF_W-1] && (|r[COEF_W-2:0]))) begin
				res = CSAT_MIN;
			end else begin
				res = COEF_W'(RC_W'(0) - r);
			end
		end else begin
			if (|r[RC_W-1:COEF_W-1]) begin
				res = CSAT_MAX;
			end else begin
				res = r[COEF_W-1:0];
			end
		end
		return res;
	endfunction

	assign coef_x_d = coef_round(sum_bxs_q, mpx_s1);
	assign coef_y_d = coef_round(sum_bys_q, mpy_s1);

	// Corrected sample in Q.23, then rounded and saturated.
	always_comb begin
		logic signed [DATA_W:0]  d;
		logic signed [V_W-1:0]   v;
		logic [V_W-1:0]          mag;
		logic [V_W-1:0]          rs;
		logic [RR_W-1:0]         r;
		d = (DATA_W+1)'(rd_s) - (pe_q ? (DATA_W+1)'(mean_q) : '0);
		v = V_W'(d) <<< RD_SH;
		if (te_q) begin
			v = v - (V_W'(rpx_s1) + V_W'(rpy_s1));
		end
		mag = v[V_W-1] ? V_W'(-v) : V_W'(v);
		rs  = mag + V_W'(1 << (RD_SH - 1));
		r   = rs[V_W-1:RD_SH];
		if (v[V_W-1]) begin
			if ((|r[RR_W-1:DATA_W]) || (r[DATA_W-1] && (|r[DATA_W-2:0]))) begin
				rd_val = SAT_MIN;
			end else begin
				rd_val = DATA_W'(RR_W'(0) - r);
			end
		end else begin
			if (|r[RR_W-1:DATA_W-1]) begin
				rd_val = SAT_MAX;
			end else begin
				rd_val = r[DATA_W-1:0];
			end
		end
	end

	assign rd_ok = ready_q && ({1'b0, idx_q} < n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q        <= CNT_W'(MAX_SAMPLES);
			pe_q        <= 1'b1;
			te_q        <= 1'b1;
			cnt_q       <= '0;
			ready_q     <= 1'b0;
			sum_s_q     <= '0;
			sum_bx_q    <= '0;
			sum_by_q    <= '0;
			sum_bxs_q   <= '0;
			sum_bys_q   <= '0;
			mean_q      <= '0;
			coef_x_q    <= '0;
			coef_y_q    <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			div_neg_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SAMPLE_COUNT: begin
						sc_q      <= cfg_wdata;
						cnt_q     <= '0;
						ready_q   <= 1'b0;
						sum_s_q   <= '0;
						sum_bx_q  <= '0;
						sum_by_q  <= '0;
						sum_bxs_q <= '0;
						sum_bys_q <= '0;
					end
					CFG_PISTON_ENABLE: pe_q <= cfg_wdata[0];
					CFG_TILT_ENABLE:   te_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			if (cmd.ld_mul && restart_now) begin
				ready_q   <= 1'b0;
				sum_s_q   <= '0;
				sum_bx_q  <= '0;
				sum_by_q  <= '0;
				sum_bxs_q <= '0;
				sum_bys_q <= '0;
			end
			if (cmd.ld_acc) begin
				sum_s_q   <= sum_s_q + SUM_W'(smp_q);
				sum_bx_q  <= sum_bx_q + SUM_W'(bx_q);
				sum_by_q  <= sum_by_q + SUM_W'(by_q);
				sum_bxs_q <= sum_bxs_q + PSUM_W'(pbx_s1);
				sum_bys_q <= sum_bys_q + PSUM_W'(pby_s1);
				cnt_q     <= CNT_W'(wr_idx_s1) + CNT_W'(1);
			end
			if (cmd.div_init) begin
				quo_q     <= DIV_W'(sum_mag) + DIV_W'(n_eff >> 1);
				rem_q     <= '0;
				div_cnt_q <= DIV_CNT_W'(DIV_W - 1);
				div_neg_q <= sum_s_q[SUM_W-1];
			end
			if (cmd.div_step) begin
				rem_q     <= qbit ? CNT_W'(trial - {1'b0, n_eff}) : trial[CNT_W-1:0];
				quo_q     <= {quo_q[DIV_W-2:0], qbit};
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
			if (cmd.mean_set) begin
				mean_q <= div_neg_q ? DATA_W'((DATA_W+1)'(0) - q_mean) : q_mean[DATA_W-1:0];
			end
			if (cmd.coef_fin) begin
				coef_x_q <= coef_x_d;
				coef_y_q <= coef_y_d;
				ready_q  <= 1'b1;
			end
			if (cmd.rd_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q <= in_data[DATA_W-1:0];
			bx_q  <= in_data[DATA_W+BASIS_W-1:DATA_W];
			by_q  <= in_data[RAM_W-1:DATA_W+BASIS_W];
			idx_q <= in_data[RAM_W+IDX_W-1:RAM_W];
		end
		if (cmd.ld_mul) begin
			wr_idx_s1 <= wr_idx;
			pbx_s1    <= bx_q * smp_q;
			pby_s1    <= by_q * smp_q;
		end
		if (cmd.coef_mul) begin
			mpx_s1 <= m_sel * sum_bx_q;
			mpy_s1 <= m_sel * sum_by_q;
		end
		if (cmd.rd_mul_x) begin
			rpx_s1 <= rd_bx * coef_x_q;
		end
		if (cmd.rd_mul_y) begin
			rpy_s1 <= rd_by * coef_y_q;
		end
		if (cmd.rd_fin) begin
			val_q   <= rd_ok ? rd_val : '0;
			oidx_q  <= idx_q;
			ost_q   <= rd_ok ? ST_VALID : ST_NOT_READY;
			olast_q <= ({1'b0, idx_q} == (n_eff - CNT_W'(1)));
		end
	end

	assign sts.ld_last  = ((CNT_W'(wr_idx_s1) + CNT_W'(1)) == n_eff);
	assign sts.div_last = (div_cnt_q == '0);
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign out_value  = val_q;
	assign out_index  = oidx_q;
	assign out_status = ost_q;
	assign out_last   = olast_q;

	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= n_eff, "load counter beyond sample count")
	`ASSERT_IMPL(a_ready_src, clk, arst_n, $rose(ready_q), $past(cmd.coef_fin), "ready set without coefficient update")

endmodule
`default_nettype wire
